// ----- rtl/core/bbf_pkg.sv -----
package bbf_pkg;

   // Default sizes of the list store
   localparam int DEPTH_DEF    = 16;
   localparam int ID_WIDTH_DEF = 32;

   // Width of the capacity register
   localparam int CSR_WIDTH = 5;

   // Item kinds carried on the request tuser
   typedef enum logic {
      OP_QUERY    = 1'b0,
      OP_REMEMBER = 1'b1
   } bbf_op_type;

   // Command handed from the input register to the list store
   typedef struct packed {
      logic       valid;
      bbf_op_type op;
      logic       cooperated;
   } bbf_cmd_type;

endpackage

// ----- rtl/core/bounded_blacklist_fifo_cam_unit.sv -----
// Channel   Ports        Direction  Contents
// req       req_t*       in         tuser: op; tdata: partner_id, partner_reaction
// rsp       rsp_t*       out        tdata: friendly, was_listed, entries_used
// csr       csr_wr_*     in         mem_size (write only, clears the list)
//
// One item per cycle while rsp takes results; a result goes through the input register,
// then the list compare and update into the result register.
// The timing limit is the parallel compare over DEPTH entries and the
// shift-by-one compaction of the list.
// Synchronous active-high reset empties the list and sets mem_size to zero.
// A stalled rsp holds its result; req stays ready while the input register can
// move on, so one more item is taken behind a waiting result.
module bounded_blacklist_fifo_cam_unit import bbf_pkg::*; #(
   parameter int DEPTH    = DEPTH_DEF,
   parameter int ID_WIDTH = ID_WIDTH_DEF,
   localparam int CNT_W   = $clog2(DEPTH + 1),
   localparam int REQ_W   = ((ID_WIDTH + 1 + 7) / 8) * 8,
   localparam int RSP_W   = ((CNT_W + 2 + 7) / 8) * 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [REQ_W-1:0]     req_tdata,   // partner_id, partner_reaction, zero pad
   input  logic                 req_tuser,   // op
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [RSP_W-1:0]     rsp_tdata,   // friendly, was_listed, entries_used, zero pad
   input  logic                 csr_wr_en,
   input  logic [CSR_WIDTH-1:0] csr_wr_data
);

   localparam int CMP_W = (CNT_W > CSR_WIDTH) ? CNT_W : CSR_WIDTH;

   logic                 in_valid_ff;
   bbf_op_type           in_op_ff;
   logic [ID_WIDTH-1:0]  in_id_ff;
   logic                 in_coop_ff;
   logic [CSR_WIDTH-1:0] mem_size_ff;
   logic                 rsp_valid_ff;
   logic                 rsp_friendly_ff;
   logic                 rsp_listed_ff;
   logic [CNT_W-1:0]     rsp_count_ff;
   logic                 advance;
   logic [CMP_W-1:0]     size_wide;
   logic [CNT_W-1:0]     cap;
   bbf_cmd_type          cmd;
   logic                 hit;
   logic [CNT_W-1:0]     count_after;

   // Move the held item into the result register when there is room
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   // Hold the capacity register
   always_ff @(posedge clock) begin
      if (reset) begin
         mem_size_ff <= '0;
      end else if (csr_wr_en) begin
         mem_size_ff <= csr_wr_data;
      end
   end

   // Clamp the capacity to the store depth
   always_comb begin
      size_wide = CMP_W'(mem_size_ff);
      if (size_wide > CMP_W'(DEPTH)) begin
         cap = CNT_W'(DEPTH);
      end else begin
         cap = size_wide[CNT_W-1:0];
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_op_ff   <= bbf_op_type'(req_tuser);
         in_id_ff   <= req_tdata[ID_WIDTH-1:0];
         in_coop_ff <= req_tdata[ID_WIDTH];
      end
   end

   assign cmd = '{valid: advance, op: in_op_ff, cooperated: in_coop_ff};

   bbf_cam #(
      .DEPTH    (DEPTH),
      .ID_WIDTH (ID_WIDTH),
      .CNT_W    (CNT_W)
   ) u_cam (
      .clock       (clock),
      .reset       (reset),
      .clear       (csr_wr_en),
      .cap         (cap),
      .cmd         (cmd),
      .id          (in_id_ff),
      .hit         (hit),
      .count_after (count_after)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_friendly_ff <= !hit;
         rsp_listed_ff   <= hit;
         rsp_count_ff    <= count_after;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'({rsp_count_ff, rsp_listed_ff, rsp_friendly_ff});

endmodule

// ----- rtl/core/bbf_cam.sv -----
module bbf_cam import bbf_pkg::*; #(
   parameter int DEPTH    = DEPTH_DEF,
   parameter int ID_WIDTH = ID_WIDTH_DEF,
   parameter int CNT_W    = $clog2(DEPTH + 1)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                clear,
   input  logic [CNT_W-1:0]    cap,
   input  bbf_cmd_type         cmd,
   input  logic [ID_WIDTH-1:0] id,
   output logic                hit,
   output logic [CNT_W-1:0]    count_after
);

   logic [ID_WIDTH-1:0] ids_ff [DEPTH];
   logic [ID_WIDTH-1:0] ids_in [DEPTH];
   logic [CNT_W-1:0]    count_ff;
   logic [CNT_W-1:0]    count_in;
   logic [DEPTH-1:0]    match;
   logic [DEPTH-1:0]    at_or_above;
   logic                remove;
   logic                append;
   logic                full;
   logic                shift_all;
   logic [CNT_W-1:0]    wr_pos;

   // Compare the id against every valid entry at once
   always_comb begin
      for (int k = 0; k < DEPTH; k++) begin
         match[k] = (CNT_W'(k) < count_ff) && (ids_ff[k] == id);
      end
   end

   // Mark entries at or above the first match
   always_comb begin
      at_or_above[0] = match[0];
      for (int k = 1; k < DEPTH; k++) begin
         at_or_above[k] = at_or_above[k-1] | match[k];
      end
   end

   assign hit = |match;

   // Decide what a remember item does to the list
   always_comb begin
      remove    = cmd.valid && (cmd.op == OP_REMEMBER) && hit && cmd.cooperated;
      append    = cmd.valid && (cmd.op == OP_REMEMBER) && !hit && !cmd.cooperated
                  && (cap != '0);
      full      = (count_ff >= cap);
      shift_all = append && full;
      wr_pos    = full ? (count_ff - CNT_W'(1)) : count_ff;
   end

   // Close the gap on removal, evict the oldest and append on a new defector
   always_comb begin
      for (int k = 0; k < DEPTH; k++) begin
         ids_in[k] = ids_ff[k];
      end
      for (int k = 0; k < DEPTH - 1; k++) begin
         if ((remove && at_or_above[k]) || shift_all) begin
            ids_in[k] = ids_ff[k+1];
         end
      end
      if (append) begin
         for (int k = 0; k < DEPTH; k++) begin
            if (CNT_W'(k) == wr_pos) begin
               ids_in[k] = id;
            end
         end
      end
   end

   // Advance the entry count
   always_comb begin
      count_in = count_ff;
      if (remove) begin
         count_in = count_ff - CNT_W'(1);
      end else if (append && !full) begin
         count_in = count_ff + CNT_W'(1);
      end
   end

   assign count_after = count_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (clear) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // Entry storage: only entries below the count are ever compared
   always_ff @(posedge clock) begin
      for (int k = 0; k < DEPTH; k++) begin
         ids_ff[k] <= ids_in[k];
      end
   end

endmodule

// ----- bench/bbf_list_checker.sv -----
`timescale 1ns / 1ps

// Watches the request, result and register channels of the blacklist unit,
// keeps its own copy of the list and checks every result in order.
module bbf_list_checker import bbf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [39:0] req_tdata,   // partner_id, partner_reaction, zero pad
   input  logic        req_tuser,   // op
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [7:0]  rsp_tdata,   // friendly, was_listed, entries_used, zero pad
   input  logic        csr_wr_en,
   input  logic [CSR_WIDTH-1:0] csr_wr_data,
   output int          fail_count,
   output int          pending
);

   localparam int DEPTH    = DEPTH_DEF;
   localparam int ID_WIDTH = ID_WIDTH_DEF;
   localparam int CNT_W    = $clog2(DEPTH + 1);

   typedef struct packed {
      logic             friendly;
      logic             was_listed;
      logic [CNT_W-1:0] entries_used;
   } lookup_verdict_type;

   // Local copy of the list, oldest entry at index 0
   logic [ID_WIDTH-1:0]  black_ids [DEPTH];
   int unsigned          black_len;
   logic [CSR_WIDTH-1:0] capacity_reg;

   lookup_verdict_type expected_verdicts [$];

   initial begin
      fail_count = 0;
      pending    = 0;
      black_len  = 0;
      capacity_reg = '0;
   end

   // Remove one entry and close the gap behind it
   task automatic drop_entry(input int unsigned pos);
      for (int unsigned k = pos; k + 1 < black_len; k++) begin
         black_ids[k] = black_ids[k + 1];
      end
      black_len--;
   endtask

   // Compare against the list, update it for a remember item, give the verdict
   task automatic update_blacklist(input bbf_op_type op, input logic [ID_WIDTH-1:0] id,
                                   input logic coop, output lookup_verdict_type verdict);
      logic        hit;
      int unsigned hit_pos;
      int unsigned cap;
      hit     = 1'b0;
      hit_pos = 0;
      for (int unsigned k = 0; k < black_len; k++) begin
         if (!hit && black_ids[k] == id) begin
            hit     = 1'b1;
            hit_pos = k;
         end
      end
      // A capacity above the store depth acts as the full depth
      cap = (capacity_reg > DEPTH) ? DEPTH : capacity_reg;
      if (op == OP_REMEMBER) begin
         if (hit) begin
            if (coop) drop_entry(hit_pos);
         end else if (!coop && cap > 0) begin
            // Evict the oldest entry when the list is full
            if (black_len >= cap) drop_entry(0);
            if (black_len < DEPTH) begin
               black_ids[black_len] = id;
               black_len++;
            end
         end
      end
      verdict.friendly     = !hit;
      verdict.was_listed   = hit;
      verdict.entries_used = CNT_W'(black_len);
   endtask

   always @(posedge clock) begin
      lookup_verdict_type want;
      lookup_verdict_type got;
      if (reset) begin
         expected_verdicts.delete();
         black_len    = 0;
         capacity_reg = '0;
      end else begin
         // Register write sets the capacity and empties the list
         if (csr_wr_en) begin
            capacity_reg = csr_wr_data;
            black_len    = 0;
         end

         // Check an accepted result against the oldest expectation
         if (rsp_tvalid && rsp_tready) begin
            got.friendly     = rsp_tdata[0];
            got.was_listed   = rsp_tdata[1];
            got.entries_used = rsp_tdata[2 +: CNT_W];
            if (expected_verdicts.size() == 0) begin
               if (fail_count < 10)
                  $display("%0t: unexpected result friendly=%0b was_listed=%0b entries=%0d",
                           $realtime, got.friendly, got.was_listed, got.entries_used);
               fail_count++;
            end else begin
               want = expected_verdicts.pop_front();
               if (got.friendly !== want.friendly || got.was_listed !== want.was_listed ||
                   got.entries_used !== want.entries_used) begin
                  if (fail_count < 10)
                     $display("%0t: mismatch exp friendly=%0b listed=%0b used=%0d act %0b %0b %0d",
                              $realtime, want.friendly, want.was_listed, want.entries_used,
                              got.friendly, got.was_listed, got.entries_used);
                  fail_count++;
               end
            end
         end

         // Predict the result of an accepted item
         if (req_tvalid && req_tready) begin
            update_blacklist(bbf_op_type'(req_tuser), req_tdata[ID_WIDTH-1:0],
                             req_tdata[ID_WIDTH], want);
            expected_verdicts.push_back(want);
         end
      end
      pending = expected_verdicts.size();
   end

endmodule

// ----- bench/tb_bounded_blacklist_fifo_cam_unit.sv -----
`timescale 1ns / 1ps

module tb_bounded_blacklist_fifo_cam_unit;
   import bbf_pkg::*;

   localparam int ID_WIDTH        = ID_WIDTH_DEF;
   localparam int PHASE_ITEMS     = 62;
   localparam int SQUEEZE_CYCLES  = 300;
   localparam int SETTLE_CYCLES   = 6;

   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [39:0]          req_tdata  = '0;   // partner_id, partner_reaction, zero pad
   logic                 req_tuser  = 1'b0; // op
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [7:0]           rsp_tdata;         // friendly, was_listed, entries_used, zero pad
   logic                 csr_wr_en   = 1'b0;
   logic [CSR_WIDTH-1:0] csr_wr_data = '0;

   int fail_count;
   int pending;

   // Sender asks the receiver for one long hold-off
   bit squeeze_req  = 1'b0;
   bit squeeze_done = 1'b0;
   bit burst_mode   = 1'b0;

   bounded_blacklist_fifo_cam_unit i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   bbf_list_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .fail_count  (fail_count),
      .pending     (pending)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Give up after a generous fixed time
   initial begin
      #20_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   // Mostly short gaps between items, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (burst_mode || r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // Offer one item and hold it until the block takes it
   task automatic send_item(input bbf_op_type op, input logic [ID_WIDTH-1:0] id,
                            input logic coop);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {7'b0, coop, id};
      do @(posedge clock); while (!req_tready);
   endtask

   // Stop offering and wait until every result is back
   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [CSR_WIDTH-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      @(posedge clock);
   endtask

   // Receiver: random ready pattern plus one long hold-off on request
   initial begin
      int pick;
      int len;
      do @(posedge clock); while (reset);
      forever begin
         if (squeeze_req && !squeeze_done) begin
            rsp_tready <= 1'b0;
            repeat (SQUEEZE_CYCLES) @(posedge clock);
            squeeze_done = 1'b1;
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
               rsp_tready <= 1'b1;
               len = $urandom_range(1, 6);
            end else if (pick < 65) begin
               rsp_tready <= 1'b1;
               len = $urandom_range(30, 80);
            end else if (pick < 95) begin
               rsp_tready <= 1'b0;
               len = $urandom_range(1, 3);
            end else begin
               rsp_tready <= 1'b0;
               len = $urandom_range(15, 50);
            end
            repeat (len) @(posedge clock);
         end
      end
   end

   // Stimulus
   initial begin
      logic [CSR_WIDTH-1:0] caps [8];
      logic [ID_WIDTH-1:0]  id_pool [$];
      logic [ID_WIDTH-1:0]  id;
      bbf_op_type           op;
      logic                 coop;
      int                   pool_size;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Capacity zero out of reset: nothing gets stored
      send_item(OP_REMEMBER, 32'hDEAD_BEEF, 1'b0);
      send_item(OP_QUERY, 32'hDEAD_BEEF, 1'b1);
      drain();

      // Directed walk through append, evict, remove and no-change cases
      write_capacity(5'd4);
      send_item(OP_REMEMBER, 32'h0000_0000, 1'b0);
      send_item(OP_REMEMBER, 32'hFFFF_FFFF, 1'b0);
      send_item(OP_REMEMBER, 32'h1234_5678, 1'b0);
      send_item(OP_REMEMBER, 32'hA5A5_A5A5, 1'b0);
      send_item(OP_QUERY, 32'h1234_5678, 1'b1);
      send_item(OP_QUERY, 32'h8765_4321, 1'b0);
      // listed and defected again: entry stays put
      send_item(OP_REMEMBER, 32'h1234_5678, 1'b0);
      // unlisted and cooperated: no change
      send_item(OP_REMEMBER, 32'h5A5A_5A5A, 1'b1);
      // full list: oldest entry goes out
      send_item(OP_REMEMBER, 32'h5A5A_5A5A, 1'b0);
      send_item(OP_QUERY, 32'h0000_0000, 1'b0);
      // remove the first, then the last, then the first, then the only one left
      send_item(OP_REMEMBER, 32'hFFFF_FFFF, 1'b1);
      send_item(OP_QUERY, 32'hA5A5_A5A5, 1'b0);
      send_item(OP_REMEMBER, 32'h5A5A_5A5A, 1'b1);
      send_item(OP_REMEMBER, 32'h1234_5678, 1'b1);
      send_item(OP_REMEMBER, 32'hA5A5_A5A5, 1'b1);
      send_item(OP_REMEMBER, 32'hA5A5_A5A5, 1'b1);
      drain();

      // Random phases over several capacities, the extremes among them
      caps = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd5, 5'd17, 5'd2, 5'($urandom_range(0, 31))};
      foreach (caps[p]) begin
         write_capacity(caps[p]);
         // Draw most ids from a small pool so entries get hit and evicted
         id_pool.delete();
         pool_size = $urandom_range(3, 24);
         repeat (pool_size) id_pool.push_back($urandom);
         burst_mode = (p == 3);
         if (p == 2) squeeze_req = 1'b1;
         repeat (PHASE_ITEMS) begin
            if ($urandom_range(0, 99) < 85)
               id = id_pool[$urandom_range(0, pool_size - 1)];
            else
               id = $urandom;
            op   = ($urandom_range(0, 99) < 30) ? OP_QUERY : OP_REMEMBER;
            coop = ($urandom_range(0, 99) < 45);
            send_item(op, id, coop);
         end
         drain();
      end
      burst_mode = 1'b0;

      // Verdict
      if (fail_count == 0 && pending == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
